// File: sv/osa_distance_name_suggester_unit_assert.svh
// Assertion macros shared by the suggester checker.
`ifndef OSA_DISTANCE_NAME_SUGGESTER_UNIT_ASSERT_SVH
`define OSA_DISTANCE_NAME_SUGGESTER_UNIT_ASSERT_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define OSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but checked during reset as well.
`define OSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/osa_pkg.sv
// Shared types, constants and helpers for the name suggester.
`default_nettype none
package osa_pkg;
    localparam int MAX_NAME  = 64;
    localparam int LEN_W     = $clog2(MAX_NAME + 2);
    localparam int QADDR_W   = $clog2(MAX_NAME);
    localparam int COL_DEPTH = MAX_NAME + 1;
    localparam int CELL_W    = LEN_W;
    localparam int IDX_W     = 16;
    localparam int NAME_DEPTH = 2 * MAX_NAME;
    localparam int NADDR_W   = $clog2(NAME_DEPTH);
    localparam logic [1:0] DIST_NONE = 2'd3;
    localparam logic [1:0] LIMIT_CAP = 2'd2;

    typedef enum logic [1:0] {
        REQ_QUERY    = 2'd0,
        REQ_CAND     = 2'd1,
        REQ_CAND_END = 2'd2,
        REQ_LIST_END = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_CMP  = 3'b100
    } t_state;

    // min(len / 3, 2) without a divider
    function automatic logic [1:0] f_limit(input logic [LEN_W-1:0] len);
        logic [1:0] lim;
        if (len >= LEN_W'(6)) lim = LIMIT_CAP;
        else if (len >= LEN_W'(3)) lim = 2'd1;
        else lim = 2'd0;
        return lim;
    endfunction
endpackage
`default_nettype wire

// File: sv/osa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module osa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/osa_distance_name_suggester_unit.sv
// Top level of the edit-distance name suggester.
`default_nettype none
// Name suggester. Load a query name with query beats, then stream candidate
// names byte by byte, each closed by an end-of-candidate beat; an end-of-list
// beat emits one result beat (found flag, best index, best distance) and
// clears all state. The distance is the optimal-string-alignment edit
// distance, accepted only up to min(query length / 3, 2). Query beats,
// end-of-list beats and end-of-candidate beats are taken in the idle
// state. A candidate byte starts a column sweep by the single cell unit
// that sweeps one DP column entry per cycle through the column RAM; the
// read pipeline then drains and the unit returns to idle before the next
// accept. An end-of-candidate beat that ties in distance with an
// equal-length best is followed by a byte-wise name compare. No clearing
// pass follows reset.
module osa_distance_name_suggester_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // [7:0] char_code, [23:8] candidate_index
    input  wire osa_pkg::t_req i_s_tuser, // req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,  // [15:0] best_index, [17:16] best_distance
    output logic             o_m_tuser   // found
);
    import osa_pkg::*;

    localparam int CADDR_W = $clog2(COL_DEPTH);

    t_state r_st, n_st;
    logic [LEN_W-1:0]  r_qlen, r_clen, r_blen, r_cmp_len;
    logic              r_too_long, r_sel, r_tie;
    logic [7:0]        r_rc0;          // most recent candidate byte
    logic [IDX_W-1:0]  r_bid;
    logic [1:0]        r_bdist;
    logic [CELL_W-1:0] r_dist;         // bottom entry of the newest column
    // column sweep
    logic [LEN_W-1:0]  r_iss, r_pi, r_j;
    logic              r_pend;
    logic [7:0]        r_c, r_p, r_qprev;
    logic [CELL_W-1:0] r_left, r_diag, r_old1, r_old2;
    // output register
    logic              r_ovalid, r_ofound;
    logic [IDX_W-1:0]  r_oidx;
    logic [1:0]        r_odist;

    logic acc;
    logic [7:0] s_char;
    logic [IDX_W-1:0] s_idx;
    assign s_char = i_s_tdata[7:0];
    assign s_idx  = i_s_tdata[8 +: IDX_W];
    assign o_s_tready = (r_st == ST_IDLE) && !(r_ovalid && i_s_tuser == REQ_LIST_END);
    assign acc = i_s_tvalid && o_s_tready;

    // issue side of the current sweep
    logic issue_run, issue_cmp;
    assign issue_run = (r_st == ST_RUN) && (r_iss <= r_qlen);
    assign issue_cmp = (r_st == ST_CMP) && (r_iss < r_cmp_len);

    // query store
    logic [7:0] q_rd;
    osa_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_qram (
        .i_clk  (i_clk),
        .i_we   (acc && i_s_tuser == REQ_QUERY && r_qlen < LEN_W'(MAX_NAME)),
        .i_waddr(r_qlen[QADDR_W-1:0]),
        .i_wdata(s_char),
        .i_raddr(QADDR_W'(r_iss - LEN_W'(1))),
        .o_rdata(q_rd)
    );

    // column store: entry holds {previous, older}
    logic [2*CELL_W-1:0] col_rd;
    logic [CELL_W-1:0] prev_i, older_i, d_a, d_b, d_c, d_t, d_min, d_cell;
    logic trans;
    assign prev_i  = (r_j == LEN_W'(1)) ? CELL_W'(r_pi) : col_rd[2*CELL_W-1:CELL_W];
    assign older_i = col_rd[CELL_W-1:0];
    always_comb begin
        d_a = prev_i + CELL_W'(1);
        d_b = r_left + CELL_W'(1);
        d_c = r_diag + CELL_W'(q_rd != r_c);
        d_t = r_old2 + CELL_W'(1);
        d_min = (d_b < d_a) ? d_b : d_a;
        if (d_c < d_min) d_min = d_c;
        trans = (r_pi > LEN_W'(1)) && (r_j > LEN_W'(1)) && (q_rd == r_p)
                && (r_qprev == r_c);
        d_cell = (trans && d_t < d_min) ? d_t : d_min;
    end
    osa_ram #(.WIDTH(2*CELL_W), .DEPTH(COL_DEPTH)) u_colram (
        .i_clk  (i_clk),
        .i_we   (r_pend && r_st == ST_RUN),
        .i_waddr(CADDR_W'(r_pi)),
        .i_wdata({d_cell, prev_i}),
        .i_raddr(CADDR_W'(r_iss)),
        .o_rdata(col_rd)
    );

    // name buffers, duplicated so the compare reads both halves at once
    logic n_we;
    logic [NADDR_W-1:0] n_waddr, n_ra, n_rb;
    logic [7:0] name_a, name_b;
    assign n_we    = acc && i_s_tuser == REQ_CAND && r_clen < LEN_W'(MAX_NAME);
    assign n_waddr = {~r_sel, r_clen[QADDR_W-1:0]};
    assign n_ra    = {~r_sel, r_iss[QADDR_W-1:0]};
    assign n_rb    = {r_sel, r_iss[QADDR_W-1:0]};
    osa_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_a (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(s_char),
        .i_raddr(n_ra), .o_rdata(name_a)
    );
    osa_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_b (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(s_char),
        .i_raddr(n_rb), .o_rdata(name_b)
    );

    // end-of-candidate decision
    logic [1:0] lim;
    logic cand_ok, cand_better, cand_equal;
    assign lim = f_limit(r_qlen);
    assign cand_ok = (r_clen != '0) && (r_clen <= LEN_W'(MAX_NAME)) && !r_too_long
                     && (lim != 2'd0) && (r_dist != '0)
                     && (r_dist <= CELL_W'(lim));
    assign cand_better = cand_ok && (r_dist < CELL_W'(r_bdist));
    assign cand_equal  = cand_ok && (r_dist == CELL_W'(r_bdist));

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (acc && i_s_tuser == REQ_CAND && r_clen < LEN_W'(MAX_NAME)
                    && r_qlen != '0) n_st = ST_RUN;
                if (acc && i_s_tuser == REQ_CAND_END && cand_equal
                    && r_clen == r_blen) n_st = ST_CMP;
            end
            ST_RUN:  if (!issue_run && !r_pend) n_st = ST_IDLE;
            ST_CMP:  if (!issue_cmp && !r_pend) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_qlen <= '0; r_clen <= '0; r_blen <= '0;
            r_too_long <= 1'b0; r_sel <= 1'b0; r_tie <= 1'b0;
            r_rc0 <= '0; r_bid <= '0; r_bdist <= DIST_NONE;
            r_pend <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_pend <= issue_run || issue_cmp;
            if (issue_run || issue_cmp) r_iss <= r_iss + LEN_W'(1);
            r_pi <= r_iss;
            if (o_m_tvalid && i_m_tready) r_ovalid <= 1'b0;
            // one DP cell per cycle
            if (r_pend && r_st == ST_RUN) begin
                r_left <= d_cell; r_diag <= prev_i; r_qprev <= q_rd;
                r_old2 <= r_old1; r_old1 <= older_i; r_dist <= d_cell;
            end
            // one name byte pair per cycle
            if (r_pend && r_st == ST_CMP && name_a != name_b) r_tie <= 1'b1;
            if (acc) begin
                case (i_s_tuser)
                    REQ_QUERY: begin
                        r_clen <= '0; r_rc0 <= '0;
                        if (r_qlen < LEN_W'(MAX_NAME)) r_qlen <= r_qlen + LEN_W'(1);
                        else r_too_long <= 1'b1;
                    end
                    REQ_CAND: begin
                        if (r_clen >= LEN_W'(MAX_NAME)) begin
                            r_clen <= LEN_W'(MAX_NAME + 1);
                        end else begin
                            // start a column sweep for byte j = clen + 1
                            r_clen <= r_clen + LEN_W'(1);
                            r_j    <= r_clen + LEN_W'(1);
                            r_c    <= s_char; r_p <= r_rc0; r_rc0 <= s_char;
                            r_iss  <= LEN_W'(1);
                            r_left <= CELL_W'(r_clen) + CELL_W'(1);
                            r_diag <= CELL_W'(r_clen);
                            r_old1 <= CELL_W'(r_clen) - CELL_W'(1);
                            r_dist <= CELL_W'(r_clen) + CELL_W'(1);
                        end
                    end
                    REQ_CAND_END: begin
                        r_clen <= '0; r_rc0 <= '0;
                        if (cand_better) begin
                            r_bdist <= r_dist[1:0]; r_sel <= ~r_sel;
                            r_blen <= r_clen; r_bid <= s_idx; r_tie <= 1'b0;
                        end else if (cand_equal) begin
                            if (r_clen != r_blen) r_tie <= 1'b1;
                            r_iss <= '0; r_cmp_len <= r_clen;
                        end
                    end
                    REQ_LIST_END: begin
                        r_ovalid <= 1'b1;
                        r_ofound <= !r_tie && !r_too_long && lim != 2'd0
                                    && r_bdist <= LIMIT_CAP;
                        r_oidx  <= r_bid; r_odist <= r_bdist;
                        // drop the list state back to its reset values
                        r_qlen <= '0; r_clen <= '0; r_blen <= '0;
                        r_too_long <= 1'b0; r_sel <= 1'b0; r_tie <= 1'b0;
                        r_rc0 <= '0; r_bid <= '0; r_bdist <= DIST_NONE;
                    end
                    default: r_clen <= r_clen;
                endcase
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ofound;
    assign o_m_tdata  = {6'd0, r_ofound ? r_odist : 2'd0,
                         r_ofound ? r_oidx : IDX_W'(0)};
endmodule
`default_nettype wire

// File: sv/osa_checker.sv
// Port-level checker for the name suggester, bound to the top level.
`default_nettype none
`include "osa_distance_name_suggester_unit_assert.svh"
module osa_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_s_tvalid,
    input wire logic          o_s_tready,
    input wire osa_pkg::t_req i_s_tuser,
    input wire logic          o_m_tvalid,
    input wire logic          i_m_tready,
    input wire logic [23:0]   o_m_tdata,
    input wire logic          o_m_tuser
);
    import osa_pkg::*;

    `OSA_ASSERT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result beat dropped or changed under stall")
    `OSA_ASSERT(a_nf_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> o_m_tdata == 24'd0, "not-found beat carries nonzero data")
    `OSA_ASSERT(a_dist, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> (o_m_tdata[17:16] == 2'd1 || o_m_tdata[17:16] == 2'd2), "found beat with bad distance")
    `OSA_ASSERT(a_cause, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tuser == REQ_LIST_END), "result beat without end of list")
    `OSA_ASSERT_ALWAYS(a_rst, i_clk, !$past(i_rst_n) |-> !o_m_tvalid, "result valid right after reset")
endmodule

bind osa_distance_name_suggester_unit osa_checker u_osa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready), .i_s_tuser(i_s_tuser), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
);
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the edit-distance name suggester.
`default_nettype none
module tb;
    import osa_pkg::*;

    localparam int MAXN = MAX_NAME;

    typedef struct packed {
        logic        found;
        logic [15:0] index;
        logic [1:0]  distance;
    } t_sugg;

    typedef struct {
        t_req        kind;
        logic [7:0]  ch;
        logic [15:0] idx;
        bit          has_exp;
        t_sugg       exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    t_req        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;

    osa_distance_name_suggester_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    // predictor state
    logic [7:0]  qry [MAXN];
    int          qlen, qlong;
    int          col_old [MAXN+1];
    int          col_prev [MAXN+1];
    logic [7:0]  last_ch;
    int          clen;
    logic [7:0]  names [2*MAXN];
    int          bsel, blen, bdist, tie;
    logic [15:0] bid;

    t_sugg sugg_q[$];
    int    errors;
    int    send_idle, recv_stall;

    function automatic int lim_of(int n);
        return (n / 3 > 2) ? 2 : n / 3;
    endfunction

    task automatic clear_pred();
        qlen = 0; qlong = 0; last_ch = 0; clen = 0;
        bsel = 0; blen = 0; bid = 0; bdist = 3; tie = 0;
        for (int i = 0; i <= MAXN; i++) begin
            col_old[i] = 0; col_prev[i] = 0;
        end
    endtask

    task automatic take_byte(logic [7:0] c);
        int col [MAXN+1];
        int j, d, cost;
        if (clen >= MAXN) begin
            clen = MAXN + 1;
            return;
        end
        j = clen + 1;
        if (j == 1) for (int i = 0; i <= qlen; i++) col_prev[i] = i;
        col[0] = j;
        for (int i = 1; i <= qlen; i++) begin
            cost = (qry[i-1] == c) ? 0 : 1;
            d = col_prev[i] + 1;
            if (col[i-1] + 1 < d) d = col[i-1] + 1;
            if (col_prev[i-1] + cost < d) d = col_prev[i-1] + cost;
            // adjacent transposition
            if (i > 1 && j > 1 && qry[i-1] == last_ch && qry[i-2] == c &&
                col_old[i-2] + 1 < d) d = col_old[i-2] + 1;
            col[i] = d;
        end
        col_old = col_prev;
        for (int i = 0; i <= qlen; i++) col_prev[i] = col[i];
        names[(bsel ^ 1) * MAXN + j - 1] = c;
        last_ch = c;
        clen = j;
    endtask

    task automatic end_cand(logic [15:0] idx);
        int len, d, cur;
        bit same;
        len = clen;
        clen = 0; last_ch = 0;
        if (len == 0 || len > MAXN || qlong != 0 || lim_of(qlen) == 0) return;
        d = col_prev[qlen];
        if (d == 0 || d > lim_of(qlen)) return;
        cur = bsel ^ 1;
        if (d < bdist) begin
            bdist = d; bsel = cur; blen = len; bid = idx; tie = 0;
        end else if (d == bdist) begin
            same = (len == blen);
            for (int i = 0; i < len && same; i++)
                if (names[cur*MAXN+i] != names[bsel*MAXN+i]) same = 0;
            if (!same) tie = 1;
        end
    endtask

    // advance the predictor by one accepted beat
    task automatic predict_beat(t_req k, logic [7:0] c, logic [15:0] idx);
        t_sugg s;
        bit f;
        case (k)
            REQ_QUERY: begin
                clen = 0; last_ch = 0;
                if (qlen < MAXN) begin
                    qry[qlen] = c; qlen++;
                end else qlong = 1;
            end
            REQ_CAND: take_byte(c);
            REQ_CAND_END: end_cand(idx);
            default: begin
                f = !tie && !qlong && lim_of(qlen) > 0 && bdist <= 2;
                s.found = f;
                s.index = f ? bid : 16'd0;
                s.distance = f ? 2'(bdist) : 2'd0;
                sugg_q.push_back(s);
                clear_pred();
            end
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("simulation failed");
        $finish;
    end

    // result side: stall at random, compare on each accepted beat
    always @(posedge i_clk) begin
        t_sugg got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata[15:0], o_m_tdata[17:16]};
            if (sugg_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = sugg_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp found=%b idx=%h dist=%0d, got found=%b idx=%h dist=%0d",
                                 want.found, want.index, want.distance,
                                 got.found, got.index, got.distance);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_stall);

    // drive one beat, honoring the sender idle rate
    task automatic send(t_req k, logic [7:0] c, logic [15:0] idx);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= k;
        i_s_tdata  <= {idx, c};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_beat(k, c, idx);
        @(negedge i_clk);
    endtask

    task automatic send_name(t_req k, int n, logic [7:0] alpha);
        for (int i = 0; i < n; i++)
            send(k, (alpha == 0) ? 8'($urandom) : 8'("a" + $urandom_range(alpha-1)),
                 16'($urandom));
    endtask

    t_row rows[$];

    task automatic add_row(t_req k, logic [7:0] c, logic [15:0] idx,
                           bit he, t_sugg e);
        t_row r;
        r.kind = k; r.ch = c; r.idx = idx; r.has_exp = he; r.exp = e;
        rows.push_back(r);
    endtask

    initial begin
        t_sugg none_s;
        int n, mode, qn;
        logic [7:0] q_copy [MAXN];
        none_s = '0;
        errors = 0;
        send_idle = 0; recv_stall = 0;
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = '0; i_s_tuser = REQ_QUERY;
        clear_pred();
        for (int i = 0; i < 2*MAXN; i++) names[i] = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        // directed table: empty list, short query, near match, byte zero
        add_row(REQ_LIST_END, 8'h00, 16'h0000, 1'b1, none_s);
        add_row(REQ_QUERY, "a", 16'h0000, 1'b0, none_s);
        add_row(REQ_QUERY, "b", 16'h0000, 1'b0, none_s);
        add_row(REQ_CAND, "a", 16'h0000, 1'b0, none_s);
        add_row(REQ_CAND_END, 8'h00, 16'hffff, 1'b0, none_s);
        add_row(REQ_LIST_END, 8'hff, 16'hffff, 1'b1, none_s);  // zero limit
        add_row(REQ_QUERY, 8'h00, 16'h0000, 1'b0, none_s);
        add_row(REQ_QUERY, 8'hff, 16'h0000, 1'b0, none_s);
        add_row(REQ_QUERY, "c", 16'h0000, 1'b0, none_s);
        add_row(REQ_CAND, 8'hff, 16'h0000, 1'b0, none_s);      // transposed
        add_row(REQ_CAND, 8'h00, 16'h0000, 1'b0, none_s);
        add_row(REQ_CAND, "c", 16'h0000, 1'b0, none_s);
        add_row(REQ_CAND_END, 8'h00, 16'hffff, 1'b0, none_s);
        add_row(REQ_CAND, 8'h00, 16'h0000, 1'b0, none_s);      // equal: skipped
        add_row(REQ_CAND, 8'hff, 16'h0000, 1'b0, none_s);
        add_row(REQ_CAND, "c", 16'h0000, 1'b0, none_s);
        add_row(REQ_CAND_END, 8'h00, 16'h1234, 1'b0, none_s);
        add_row(REQ_CAND_END, 8'h00, 16'h5555, 1'b0, none_s);  // empty
        add_row(REQ_CAND, "x", 16'h0000, 1'b0, none_s);        // dropped by end of list
        add_row(REQ_LIST_END, 8'h00, 16'h0000, 1'b1, '{1'b1, 16'hffff, 2'd1});
        foreach (rows[i]) begin
            if (rows[i].has_exp && !(sugg_q.size() == 0))
                $display("table row %0d queued behind results", i);
            send(rows[i].kind, rows[i].ch, rows[i].idx);
            if (rows[i].has_exp && sugg_q.size() > 0 &&
                sugg_q[$] !== rows[i].exp) begin
                errors++;
                $display("table row %0d: predictor disagrees with table", i);
            end
        end

        // long query and long candidate
        for (int i = 0; i < MAXN + 2; i++) send(REQ_QUERY, 8'($urandom), 16'h0000);
        send_name(REQ_CAND, 3, 8'd0);
        send(REQ_CAND_END, 8'h00, 16'h0001);
        send(REQ_LIST_END, 8'h00, 16'h0000);
        send_name(REQ_QUERY, 6, 8'd2);
        send_name(REQ_CAND, MAXN + 2, 8'd2);
        send(REQ_CAND_END, 8'h00, 16'h00aa);
        send(REQ_LIST_END, 8'h00, 16'h0000);

        // random lists, four idling phases
        n = 0;
        while (n < 880) begin
            case ((n * 4) / 880)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 62; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 62; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            qn = $urandom_range(10);
            for (int i = 0; i < qn; i++) begin
                q_copy[i] = 8'("a" + $urandom_range(2));
                send(REQ_QUERY, q_copy[i], 16'($urandom)); n++;
            end
            repeat ($urandom_range(6)) begin
                mode = $urandom_range(9);
                if (mode < 6) begin
                    // mutate the query a little
                    for (int i = 0; i < qn; i++) begin
                        if ($urandom_range(5) == 0) continue;
                        send(REQ_CAND, ($urandom_range(5) == 0) ?
                             8'("a" + $urandom_range(2)) : q_copy[i], 16'h0000); n++;
                    end
                    if ($urandom_range(3) == 0) begin
                        send(REQ_CAND, 8'("a" + $urandom_range(2)), 16'h0000); n++;
                    end
                end else if (mode < 8) begin
                    send_name(REQ_CAND, $urandom_range(8), 8'd3); n += 4;
                end else if (mode == 8) begin
                    send_name(REQ_CAND, $urandom_range(4), 8'd0); n += 2;
                end else begin
                    send(t_req'($urandom_range(2)), 8'($urandom), 16'($urandom)); n++;
                end
                send(REQ_CAND_END, 8'($urandom), 16'($urandom)); n++;
            end
            send(REQ_LIST_END, 8'($urandom), 16'($urandom)); n++;
        end

        i_s_tvalid <= 0;
        send_idle = 0;
        while (sugg_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && sugg_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+sv
sv/osa_pkg.sv
sv/osa_ram.sv
sv/osa_distance_name_suggester_unit.sv
sv/osa_checker.sv
dv/tb.sv
